// ===== sv/bsx_pkg.sv =====
// Shared types, constants and helpers of the byte stuffer with XOR check.
package bsx_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] FLAG_BYTE_RST   = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd125;
    localparam logic [BYTE_W-1:0] FLAG_CODE_RST   = 8'd94;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd93;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLAG_BYTE   = 2'd0,
        CFG_ESCAPE_BYTE = 2'd1,
        CFG_FLAG_CODE   = 2'd2,
        CFG_ESCAPE_CODE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_FLAG  = 2'd1,
        KIND_ESC   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] flag_code;
        logic [BYTE_W-1:0] escape_code;
    } t_cfg;

    // One classified payload byte plus, on the last byte, the frame check.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_kind             data_kind;
        logic              has_check;
        logic [BYTE_W-1:0] check;
        t_kind             check_kind;
    } t_entry;

    typedef enum logic [2:0] {
        BK_IDLE      = 3'd0,
        BK_DATA      = 3'd1,
        BK_DATA_CODE = 3'd2,
        BK_CHK       = 3'd3,
        BK_CHK_CODE  = 3'd4
    } t_bk_state;

    // Flag wins when flag and escape hold the same value.
    function automatic t_kind classify(input logic [BYTE_W-1:0] b, input t_cfg c);
        t_kind k;
        if (b == c.flag_byte) begin
            k = KIND_FLAG;
        end else if (b == c.escape_byte) begin
            k = KIND_ESC;
        end else begin
            k = KIND_PLAIN;
        end
        return k;
    endfunction

endpackage

// ===== sv/bsx_if.sv =====
// Handshake channel interfaces: payload input, line output, register writes.
interface bsx_in_if;
    logic                       valid;
    logic                       ready;
    logic [bsx_pkg::BYTE_W-1:0] payload_byte;
    logic                       end_of_payload;

    modport source (output valid, payload_byte, end_of_payload, input ready);
    modport sink (input valid, payload_byte, end_of_payload, output ready);
endinterface

interface bsx_out_if;
    logic                       valid;
    logic                       ready;
    logic [bsx_pkg::BYTE_W-1:0] line_byte;
    logic                       end_of_output;

    modport source (output valid, line_byte, end_of_output, input ready);
    modport sink (input valid, line_byte, end_of_output, output ready);
endinterface

interface bsx_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bsx_pkg::CFG_IDX_W-1:0] index;
    logic [bsx_pkg::BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/bsx_front.sv =====
// Front end: take payload bytes, keep the running check, classify into queue entries.
module bsx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsx_in_if.sink            i_in,
    input  bsx_pkg::t_cfg     i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output bsx_pkg::t_entry   o_entry
);
    import bsx_pkg::*;

    logic [BYTE_W-1:0] r_check;
    logic [BYTE_W-1:0] n_check;
    logic [BYTE_W-1:0] check_now;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign check_now  = r_check ^ i_in.payload_byte;

    always_comb begin
        o_entry.data       = i_in.payload_byte;
        o_entry.data_kind  = classify(i_in.payload_byte, i_cfg);
        o_entry.has_check  = i_in.end_of_payload;
        o_entry.check      = check_now;
        o_entry.check_kind = classify(check_now, i_cfg);
    end

    // Clear the check after the last byte of a frame.
    always_comb begin
        n_check = r_check;
        if (o_push) begin
            n_check = i_in.end_of_payload ? '0 : check_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check <= '0;
        end else begin
            r_check <= n_check;
        end
    end

endmodule

// ===== sv/bsx_queue.sv =====
// Two-entry queue between the front and back ends.
module bsx_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsx_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output bsx_pkg::t_entry o_entry
);
    import bsx_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/bsx_back.sv =====
// Back end: expand queue entries into stuffed line bytes behind an output register.
module bsx_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsx_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  bsx_pkg::t_entry i_q_entry,
    output logic            o_pop,
    bsx_out_if.source       o_out
);
    import bsx_pkg::*;

    t_bk_state         r_state;
    t_bk_state         n_state;
    t_entry            r_entry;
    logic              r_ov;
    logic [BYTE_W-1:0] r_byte;
    logic              r_mark;

    logic              can_emit;
    logic              emit;
    logic              done;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_mark;

    assign can_emit = !r_ov || o_out.ready;
    assign emit     = (r_state != BK_IDLE) && can_emit;
    assign o_pop    = i_q_valid && ((r_state == BK_IDLE) || (emit && done));

    // Next state.
    always_comb begin
        n_state = r_state;
        done    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                n_state = BK_IDLE;
            end
            BK_DATA: begin
                if (r_entry.data_kind != KIND_PLAIN) begin
                    n_state = BK_DATA_CODE;
                end else if (r_entry.has_check) begin
                    n_state = BK_CHK;
                end else begin
                    done = 1'b1;
                end
            end
            BK_DATA_CODE: begin
                if (r_entry.has_check) begin
                    n_state = BK_CHK;
                end else begin
                    done = 1'b1;
                end
            end
            BK_CHK: begin
                if (r_entry.check_kind != KIND_PLAIN) begin
                    n_state = BK_CHK_CODE;
                end else begin
                    done = 1'b1;
                end
            end
            BK_CHK_CODE: begin
                done = 1'b1;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        if (r_state != BK_IDLE && !can_emit) begin
            n_state = r_state;
        end else if (r_state == BK_IDLE || done) begin
            n_state = i_q_valid ? BK_DATA : BK_IDLE;
        end
    end

    // Outputs: the line byte for the current step.
    always_comb begin
        emit_byte = r_entry.data;
        emit_mark = 1'b0;
        unique case (r_state)
            BK_DATA: begin
                emit_byte = (r_entry.data_kind == KIND_PLAIN) ? r_entry.data
                                                              : i_cfg.escape_byte;
            end
            BK_DATA_CODE: begin
                emit_byte = (r_entry.data_kind == KIND_FLAG) ? i_cfg.flag_code
                                                             : i_cfg.escape_code;
            end
            BK_CHK: begin
                if (r_entry.check_kind == KIND_PLAIN) begin
                    emit_byte = r_entry.check;
                    emit_mark = 1'b1;
                end else begin
                    emit_byte = i_cfg.escape_byte;
                end
            end
            BK_CHK_CODE: begin
                emit_byte = (r_entry.check_kind == KIND_FLAG) ? i_cfg.flag_code
                                                              : i_cfg.escape_code;
                emit_mark = 1'b1;
            end
            default: begin
                emit_byte = r_entry.data;
            end
        endcase
    end

    assign o_out.valid         = r_ov;
    assign o_out.line_byte     = r_byte;
    assign o_out.end_of_output = r_mark;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_q_entry;
        end
        if (emit) begin
            r_byte <= emit_byte;
            r_mark <= emit_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/byte_stuffer_with_xor_check.sv =====
// Top level of the byte stuffer with XOR check byte.
//
// Payload bytes enter on i_in and leave stuffed on o_out, one line byte per
// cycle at most. A byte equal to the flag byte goes out as the escape byte and
// the flag code; a byte equal to the escape byte goes out as the escape byte and
// the escape code (flag wins when both registers match). After the byte marked
// end_of_payload, the XOR of all payload bytes of the frame follows, stuffed the
// same way, with end_of_output set on its final line byte; the check then
// restarts at zero. A plain payload byte becomes one line byte, an escaped one two,
// and the last byte of a frame adds one or two more for the check; the single
// output register emits one line byte per cycle while the line side is ready. A
// two-entry queue lets input keep flowing while the output side stalls. Registers
// (flag byte, escape byte, flag code, escape code at indexes 0 to 3) are written
// on i_cfg and take effect at once; write them only while no transfer is in
// flight. i_cfg is always ready.
module byte_stuffer_with_xor_check (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsx_in_if.sink    i_in,
    bsx_out_if.source o_out,
    bsx_cfg_if.sink   i_cfg
);
    import bsx_pkg::*;

    t_cfg   r_cfg;
    t_entry front_entry;
    t_entry q_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    // Register writes: always accept, apply on the transfer.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte   <= FLAG_BYTE_RST;
            r_cfg.escape_byte <= ESCAPE_BYTE_RST;
            r_cfg.flag_code   <= FLAG_CODE_RST;
            r_cfg.escape_code <= ESCAPE_CODE_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_FLAG_BYTE:   r_cfg.flag_byte   <= i_cfg.data;
                CFG_ESCAPE_BYTE: r_cfg.escape_byte <= i_cfg.data;
                CFG_FLAG_CODE:   r_cfg.flag_code   <= i_cfg.data;
                CFG_ESCAPE_CODE: r_cfg.escape_code <= i_cfg.data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Front: classify each payload byte and fold it into the check.
    bsx_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (front_entry)
    );

    // Queue: decouple input acceptance from line output stalls.
    bsx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Back: expand entries into line bytes, one per cycle while the line side is ready.
    bsx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the byte stuffer with XOR check byte.
module tb_top;
    import bsx_pkg::*;

    // Allow this many cycles with no transfer on any channel before giving up.
    localparam int STALL_LIMIT    = 2000;
    // Hold the line side off for this long once, so the block backs up.
    localparam int LONG_HOLD      = 150;
    localparam int PHASE_ITEMS    = 68;
    localparam int HOLD_ITEMS     = 30;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int N_SETTINGS     = 6;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_payload;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              end_of_output;
    } t_line_exp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsx_in_if  in_ch ();
    bsx_out_if out_ch ();
    bsx_cfg_if cfg_ch ();

    byte_stuffer_with_xor_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    // Payload bytes waiting to be offered; the front one is the one on the bus.
    t_payload          pending_q [$];
    // Line bytes the block owes us, oldest first.
    t_line_exp         line_exp_q [$];
    // Our copy of the registers and of the frame check.
    t_cfg              cfg_model;
    logic [BYTE_W-1:0] frame_xor;

    int tx_idle_pct;
    int rx_idle_pct;
    bit long_hold_go;
    bit long_hold_done;
    int hold_cnt;

    int errors;
    int items_sent;
    int frames_sent;
    int bytes_checked;
    int stall_cycles;

    // Queue the line bytes for one byte sent stuffed; the mark rides on its
    // final line byte. A flag match wins over an escape match.
    function automatic void push_stuffed(input logic [BYTE_W-1:0] b, input logic mark);
        if (b == cfg_model.flag_byte) begin
            line_exp_q.push_back('{cfg_model.escape_byte, 1'b0});
            line_exp_q.push_back('{cfg_model.flag_code, mark});
        end else if (b == cfg_model.escape_byte) begin
            line_exp_q.push_back('{cfg_model.escape_byte, 1'b0});
            line_exp_q.push_back('{cfg_model.escape_code, mark});
        end else begin
            line_exp_q.push_back('{b, mark});
        end
    endfunction

    // Fold one accepted payload byte into the frame check and queue what
    // the line must carry for it; on the last byte append the stuffed check.
    function automatic void predict_line_bytes(input logic [BYTE_W-1:0] b, input logic last);
        frame_xor = frame_xor ^ b;
        push_stuffed(b, 1'b0);
        if (last) begin
            push_stuffed(frame_xor, 1'b1);
            frame_xor = '0;
        end
    endfunction

    // Bias toward the bytes that need stuffing under the current setting.
    function automatic logic [BYTE_W-1:0] pick_byte();
        int                r;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            b = cfg_model.flag_byte;
        end else if (r < 40) begin
            b = cfg_model.escape_byte;
        end else if (r < 45) begin
            b = cfg_model.flag_code;
        end else if (r < 50) begin
            b = cfg_model.escape_code;
        end else begin
            b = BYTE_W'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // Queue whole frames of random length and content. Steer the last byte
    // now and then so that the check itself lands on a flag or an escape.
    task automatic push_frames(input int n_items);
        int                left;
        int                len;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] b;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, 8);
            if (len > left) begin
                len = left;
            end
            acc = '0;
            for (int k = 0; k < len; k++) begin
                b = pick_byte();
                if (k == len - 1 && $urandom_range(0, 2) == 0) begin
                    b = acc ^ ($urandom_range(0, 1) ? cfg_model.flag_byte
                                                   : cfg_model.escape_byte);
                end
                acc = acc ^ b;
                pending_q.push_back('{b, k == len - 1});
            end
            left -= len;
        end
    endtask

    // Hold until every queued byte is taken and every line byte has come back,
    // then let the block settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_q.size() != 0 || in_ch.valid || line_exp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [BYTE_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_FLAG_BYTE:   cfg_model.flag_byte   = value;
            CFG_ESCAPE_BYTE: cfg_model.escape_byte = value;
            CFG_FLAG_CODE:   cfg_model.flag_code   = value;
            CFG_ESCAPE_CODE: cfg_model.escape_code = value;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input t_cfg c);
        write_reg(CFG_FLAG_BYTE,   c.flag_byte);
        write_reg(CFG_ESCAPE_BYTE, c.escape_byte);
        write_reg(CFG_FLAG_CODE,   c.flag_code);
        write_reg(CFG_ESCAPE_CODE, c.escape_code);
    endtask

    // Payload driver: keep valid up until the transfer happens, then either
    // offer the next queued byte or drop valid.
    always @(posedge i_clk) begin : payload_driver
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_line_bytes(in_ch.payload_byte, in_ch.end_of_payload);
                void'(pending_q.pop_front());
                items_sent++;
                if (in_ch.end_of_payload) begin
                    frames_sent++;
                end
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered byte until it is taken
            end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                in_ch.valid          <= 1'b1;
                in_ch.payload_byte   <= pending_q[0].data;
                in_ch.end_of_payload <= pending_q[0].last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Line monitor: check each line byte against the oldest expected one and
    // stall at random; once, drop ready for a long stretch.
    always @(posedge i_clk) begin : line_monitor
        t_line_exp want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                bytes_checked++;
                if (line_exp_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected line byte: expected none, got byte %02h end %0b",
                             $time, out_ch.line_byte, out_ch.end_of_output);
                end else begin
                    want = line_exp_q.pop_front();
                    if (want.line_byte !== out_ch.line_byte) begin
                        errors++;
                        $display("%0t: line_byte mismatch: expected %02h, got %02h",
                                 $time, want.line_byte, out_ch.line_byte);
                    end
                    if (want.end_of_output !== out_ch.end_of_output) begin
                        errors++;
                        $display("%0t: end_of_output mismatch: expected %0b, got %0b",
                                 $time, want.end_of_output, out_ch.end_of_output);
                    end
                end
            end
            if (long_hold_go && !long_hold_done) begin
                out_ch.ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt == LONG_HOLD) begin
                    long_hold_done <= 1'b1;
                end
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: end the run if no channel moves a transfer for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        t_cfg       settings_tbl [N_SETTINGS];
        logic [8:0] directed_list [26];

        // Drive every input to a known value before the first edge.
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.payload_byte   = '0;
        in_ch.end_of_payload = 1'b0;
        out_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_FLAG_BYTE;
        cfg_ch.data          = '0;
        cfg_model            = '{FLAG_BYTE_RST, ESCAPE_BYTE_RST, FLAG_CODE_RST, ESCAPE_CODE_RST};
        frame_xor            = '0;
        long_hold_go         = 1'b0;
        long_hold_done       = 1'b0;
        hold_cnt             = 0;
        errors               = 0;
        items_sent           = 0;
        frames_sent          = 0;
        bytes_checked        = 0;
        stall_cycles         = 0;

        // Sender mostly busy, receiver mostly stalled.
        tx_idle_pct = 7;
        rx_idle_pct = 73;

        // Register settings: defaults written back, both all-zero/all-one
        // extremes, flag equal to escape, codes equal to the special bytes,
        // and one random setting.
        settings_tbl[0] = '{8'h7E, 8'h7D, 8'h5E, 8'h5D};
        settings_tbl[1] = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        settings_tbl[2] = '{8'hFF, 8'h00, 8'hFF, 8'h00};
        settings_tbl[3] = '{8'h42, 8'h42, 8'h11, 8'h22};
        settings_tbl[4] = '{8'h10, 8'h20, 8'h10, 8'h20};
        settings_tbl[5] = '{BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                            BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255))};

        // Directed frames under the reset registers, {last, byte}: extremes,
        // flag and escape in data and in the check, the codes as plain data,
        // and a walking one whose check is all ones.
        directed_list = '{9'h100, 9'h1FF, 9'h17E, 9'h17D,
                          9'h05E, 9'h05D, 9'h055, 9'h0AA, 9'h07E, 9'h17D,
                          9'h001, 9'h17F,
                          9'h003, 9'h17E,
                          9'h07E, 9'h07E, 9'h07D, 9'h17D,
                          9'h080, 9'h040, 9'h020, 9'h010, 9'h008, 9'h004, 9'h002, 9'h101};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_list[k]) begin
            pending_q.push_back('{directed_list[k][7:0], directed_list[k][8]});
        end
        wait_drained();

        for (int s = 0; s < N_SETTINGS; s++) begin
            if (s == 2) begin
                // Swap: sender mostly idle, receiver mostly ready.
                tx_idle_pct = 73;
                rx_idle_pct = 7;
            end else if (s == 4) begin
                // Neither side idles; back the block up behind a long hold-off.
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                long_hold_go = 1'b1;
                push_frames(HOLD_ITEMS);
                do @(posedge i_clk);
                while (!long_hold_done);
                // Pause the sender until every owed line byte is out.
                wait_drained();
            end
            apply_setting(settings_tbl[s]);
            push_frames(PHASE_ITEMS / 2);
            wait_drained();
            push_frames(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (line_exp_q.size() != 0) begin
            $display("%0t: %0d line bytes never arrived", $time, line_exp_q.size());
        end
        $display("tb_top: %0d payload bytes in %0d frames sent, %0d line bytes checked",
                 items_sent, frames_sent, bytes_checked);
        $display("tb_top: %0d register settings incl. extremes, flag same as escape, codes as specials",
                 N_SETTINGS + 1);
        if (errors == 0 && line_exp_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
